// ----- rtl/roac_pkg.sv -----
package roac_pkg;

	localparam int COORD_W = 10;
	localparam int SPAN_W = 11;
	localparam int TOTAL_W = 21;
	localparam int LEVEL_W = 2;
	localparam int GRID_SIDE_DEF = 1024;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_ONCE = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_MULTI = 2'd2;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [SPAN_W-1:0] span_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [LEVEL_W-1:0] level_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_done;
		logic busy;
	} status_t;

endpackage

// ----- rtl/roac_rect_if.sv -----
interface roac_rect_if;
	logic valid;
	logic ready;
	roac_pkg::coord_t left_col;
	roac_pkg::coord_t top_row;
	roac_pkg::span_t rect_wide;
	roac_pkg::span_t rect_tall;

	modport source (output valid, output left_col, output top_row, output rect_wide,
		output rect_tall, input ready);
	modport sink (input valid, input left_col, input top_row, input rect_wide,
		input rect_tall, output ready);
endinterface

// ----- rtl/roac_count_if.sv -----
interface roac_count_if;
	logic valid;
	logic ready;
	roac_pkg::total_t overlap_cells;

	modport source (output valid, output overlap_cells, input ready);
	modport sink (input valid, input overlap_cells, output ready);
endinterface

// ----- rtl/roac_ram.sv -----
module roac_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/roac_dp.sv -----
module roac_dp #(
	parameter int GRID_SIDE = roac_pkg::GRID_SIDE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  roac_pkg::cmd_t cmd,
	output roac_pkg::status_t st,
	input  roac_pkg::coord_t left_col,
	input  roac_pkg::coord_t top_row,
	input  roac_pkg::span_t rect_wide,
	input  roac_pkg::span_t rect_tall,
	output roac_pkg::total_t overlap_cells
);

	localparam int AW = $clog2(GRID_SIDE);
	localparam int CELL_AW = 2 * AW;
	localparam int DEPTH = 2 ** CELL_AW;
	localparam int EW = ($clog2(GRID_SIDE + 1) > roac_pkg::SPAN_W + 1) ?
		$clog2(GRID_SIDE + 1) : roac_pkg::SPAN_W + 1;
	localparam logic [EW-1:0] GRID = EW'(GRID_SIDE);

	logic [EW-1:0] col0_q, col_q, row_q, col_end_q, row_end_q;
	logic [EW-1:0] col_sum, row_sum, col_end_d, row_end_d;
	logic [CELL_AW-1:0] clr_q;
	logic [CELL_AW-1:0] rd_addr, addr_s1, waddr;
	logic rd_valid_s1;
	roac_pkg::level_t rdata, new_lvl, wdata;
	roac_pkg::total_t total_q, out_q;
	logic we;

	assign col_sum = EW'(left_col) + EW'(rect_wide);
	assign row_sum = EW'(top_row) + EW'(rect_tall);
	assign col_end_d = (col_sum > GRID) ? GRID : col_sum;
	assign row_end_d = (row_sum > GRID) ? GRID : row_sum;

	assign rd_addr = {row_q[AW-1:0], col_q[AW-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col0_q <= EW'(left_col);
			col_q <= EW'(left_col);
			row_q <= EW'(top_row);
			col_end_q <= col_end_d;
			row_end_q <= row_end_d;
		end else if (cmd.step) begin
			if (col_q + EW'(1) == col_end_q) begin
				col_q <= col0_q;
				row_q <= row_q + EW'(1);
			end else begin
				col_q <= col_q + EW'(1);
			end
		end
		if (cmd.step) begin
			addr_s1 <= rd_addr;
		end
		if (cmd.out_load) begin
			out_q <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			rd_valid_s1 <= 1'b0;
			total_q <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + CELL_AW'(1);
			end
			rd_valid_s1 <= cmd.step;
			if (rd_valid_s1 && rdata == roac_pkg::LVL_ONCE &&
					total_q != roac_pkg::TOTAL_MAX) begin
				total_q <= total_q + roac_pkg::TOTAL_W'(1);
			end
		end
	end

	always_comb begin
		case (rdata)
			roac_pkg::LVL_NONE: new_lvl = roac_pkg::LVL_ONCE;
			roac_pkg::LVL_ONCE: new_lvl = roac_pkg::LVL_MULTI;
			default: new_lvl = rdata;
		endcase
	end

	assign we = cmd.clear | rd_valid_s1;
	assign waddr = cmd.clear ? clr_q : addr_s1;
	assign wdata = cmd.clear ? roac_pkg::LVL_NONE : new_lvl;

	roac_ram #(
		.WIDTH(roac_pkg::LEVEL_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign st.clr_last = (clr_q == '1);
	assign st.scan_done = !(row_q < row_end_q && col0_q < col_end_q);
	assign st.busy = rd_valid_s1;
	assign overlap_cells = out_q;

`ifndef SYNTH
	a_step_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (row_q < GRID && col_q < GRID && col_q < col_end_q))
		else $error("cell step outside grid or rectangle");
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.clear |=> total_q >= $past(total_q))
		else $error("overlap total went backwards");
	a_no_rmw_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !rd_valid_s1)
		else $error("cell update during clear sweep");
`endif

endmodule

// ----- rtl/roac_ctrl.sv -----
module roac_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  roac_pkg::status_t st,
	output roac_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;

	logic [2:0] state_q, state_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.scan_done) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!st.busy && (!out_valid_q || out_ready)) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/rect_overlap_area_counter.sv -----
// Paints one rectangle per rect transfer onto a GRID_SIDE x GRID_SIDE grid held in a
// single-port-write RAM of 2-bit cover levels, and returns the running count of cells
// covered at least twice as one result transfer per rectangle (saturating at 2^21-1).
// Cells past the grid edge are clipped. Painted cells are processed at one read-modify-write
// of the grid RAM per cycle; one rectangle is processed at a time, and the next is taken
// while the previous result still waits. After reset a clearing pass writes every one of
// the (2^clog2(GRID_SIDE))^2 grid cells, 1,048,576 at the default, one a cycle, before
// rect.ready rises.
module rect_overlap_area_counter #(
	parameter int GRID_SIDE = roac_pkg::GRID_SIDE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	roac_rect_if.sink rect,
	roac_count_if.source result
);

	roac_pkg::cmd_t cmd;
	roac_pkg::status_t st;

	roac_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rect.valid),
		.in_ready(rect.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.st(st),
		.cmd(cmd)
	);

	roac_dp #(
		.GRID_SIDE(GRID_SIDE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.left_col(rect.left_col),
		.top_row(rect.top_row),
		.rect_wide(rect.rect_wide),
		.rect_tall(rect.rect_tall),
		.overlap_cells(result.overlap_cells)
	);

endmodule
